### src/npt_pkg.sv
package npt_pkg;

  localparam int MAX_ENTRIES = 64;

  // Index into the table and the fill count, which must also hold MAX_ENTRIES.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES + 1) : 1;

  localparam int COORD_W   = 24;
  localparam int POINT_W   = 3 * COORD_W;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SQ_W      = PROD_W - 1;
  localparam int DIST_W    = SQ_W + 1;
  localparam int OUT_IDX_W = 6;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_BLOCKED = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // x sits in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Travels beside each entry through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  // The result carries only the low bits of a table index.
  function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] ext;
    ext = {{OUT_IDX_W{1'b0}}, idx};
    return ext[OUT_IDX_W-1:0];
  endfunction

endpackage

### src/npt_ram.sv
module npt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/npt_dist.sv
module npt_dist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  npt_pkg::point_t           query,
  input  npt_pkg::point_t           entry,
  input  npt_pkg::tag_t             in_tag,
  output npt_pkg::tag_t             out_tag,
  output logic [npt_pkg::DIST_W-1:0] sq_dist
);
  import npt_pkg::*;

  // Three stages: differences, squares, sum.
  tag_t                     tag1_r, tag2_r, tag3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [PROD_W-1:0] px, py, pz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0]        dist_r, dist_nxt;

  always_comb begin
    dx_nxt = DIFF_W'(query.x) - DIFF_W'(entry.x);
    dy_nxt = DIFF_W'(query.y) - DIFF_W'(entry.y);
    dz_nxt = DIFF_W'(query.z) - DIFF_W'(entry.z);
    px = dx_r * dx_r;
    py = dy_r * dy_r;
    pz = dz_r * dz_r;
    dist_nxt = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
    end else begin
      tag1_r.valid <= in_tag.valid;
      tag2_r.valid <= tag1_r.valid;
      tag3_r.valid <= tag2_r.valid;
    end
    tag1_r.idx <= in_tag.idx;
    tag2_r.idx <= tag1_r.idx;
    tag3_r.idx <= tag2_r.idx;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    sqx_r  <= px[SQ_W-1:0];
    sqy_r  <= py[SQ_W-1:0];
    sqz_r  <= pz[SQ_W-1:0];
    dist_r <= dist_nxt;
  end

  assign out_tag = tag3_r;
  assign sq_dist = dist_r;

endmodule

### src/nearest_point_table_top.sv
// Channel  Direction  Handshake              Payload
// in       slave      in_tvalid/in_tready    tdata: pos_x, pos_y, pos_z; tuser: req_type
// out      master     out_tvalid/out_tready  tdata: status, entry_index
// cfg      slave      cfg_valid/cfg_ready    data: query_blocked
//
// An insert, a blocked query or a query on an empty table loads the result
// register when the request is accepted. A query over the stored points reads
// the table memory one entry per cycle into a shared three-stage distance
// pipeline, followed by the running minimum compare.
// Reset is synchronous and active low; it empties the table and clears the flag.
// The block takes a new request only when idle; a finished result waits in the
// output register and a full output register holds the sequencer until taken.
module nearest_point_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] status, [7:2] entry_index
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // [0] query_blocked
);
  import npt_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  blk_r;
  logic [IDX_W-1:0]      rd_addr_r;
  point_t                query_r;
  tag_t                  ram_tag_r;
  point_t                ram_rd_data;
  tag_t                  dtag;
  logic [DIST_W-1:0]     sq_dist;
  logic                  best_vld_r;
  logic [DIST_W-1:0]     best_dist_r;
  logic [IDX_W-1:0]      best_idx_r;
  status_t               res_status_r, res_status_nxt;
  logic [OUT_IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic                  out_tvalid_r;
  logic [7:0]            out_tdata_r;

  logic       in_fire, is_query, table_full, to_scan;
  logic       last_rd, last_cmp, better;
  logic       ram_we, ram_rd_en, res_load, out_load;
  logic [IDX_W-1:0] win_idx;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign is_query   = (in_tuser[0] == REQ_QUERY);
  assign table_full = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign to_scan    = is_query && !blk_r && (cnt_r != '0);
  assign cfg_ready  = 1'b1;

  assign last_rd  = (CNT_W'(rd_addr_r) + CNT_W'(1) == cnt_r);
  assign last_cmp = dtag.valid && (CNT_W'(dtag.idx) + CNT_W'(1) == cnt_r);
  // Strictly smaller wins, so the lowest index keeps a tie.
  assign better   = dtag.valid && (!best_vld_r || (sq_dist < best_dist_r));
  assign win_idx  = better ? dtag.idx : best_idx_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = to_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_rd) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_cmp) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ram_we         = 1'b0;
    ram_rd_en      = 1'b0;
    res_load       = 1'b0;
    out_load       = 1'b0;
    res_status_nxt = STAT_OK;
    res_idx_nxt    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_query) begin
            res_load = 1'b1;
            if (table_full) begin
              res_status_nxt = STAT_FULL;
            end else begin
              ram_we      = 1'b1;
              res_idx_nxt = to_out_idx(cnt_r[IDX_W-1:0]);
            end
          end else if (blk_r) begin
            res_load       = 1'b1;
            res_status_nxt = STAT_BLOCKED;
          end else if (cnt_r == '0) begin
            res_load       = 1'b1;
            res_status_nxt = STAT_EMPTY;
          end
        end
      end
      ST_SCAN: begin
        ram_rd_en = 1'b1;
      end
      ST_DRAIN: begin
        if (last_cmp) begin
          res_load    = 1'b1;
          res_idx_nxt = to_out_idx(win_idx);
        end
      end
      ST_DONE: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: ;
    endcase
  end

  npt_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (in_tdata),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rd_data)
  );

  npt_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .query   (query_r),
    .entry   (ram_rd_data),
    .in_tag  (ram_tag_r),
    .out_tag (dtag),
    .sq_dist (sq_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      blk_r           <= 1'b0;
      ram_tag_r.valid <= 1'b0;
      best_vld_r      <= 1'b0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      ram_tag_r.valid <= ram_rd_en;
      if (cfg_valid && cfg_ready) begin
        blk_r <= cfg_data[0];
      end
      if (ram_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (in_fire) begin
        best_vld_r <= 1'b0;
      end else if (better) begin
        best_vld_r <= 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    ram_tag_r.idx <= rd_addr_r;
    if (in_fire) begin
      query_r   <= in_tdata;
      rd_addr_r <= '0;
    end else if (ram_rd_en) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
    end
    if (better) begin
      best_dist_r <= sq_dist;
      best_idx_r  <= dtag.idx;
    end
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_idx_r    <= res_idx_nxt;
    end
    if (out_load) begin
      out_tdata_r <= {res_idx_r, res_status_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The read and distance pipeline is empty whenever a new request may enter.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !ram_tag_r.valid && !dtag.valid)
    else $error("distance pipeline busy while idle");

  // The fill count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // A scan only reads entries that were written.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |-> CNT_W'(rd_addr_r) < cnt_r)
    else $error("scan read beyond stored entries");

  // Only an insert into a table with room stores a point.
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  // A result that is not ok carries index zero.
  a_err_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STAT_OK |-> out_tdata[7:2] == '0)
    else $error("nonzero index on an error result");

endmodule
